// ===== hw/rtl/sitda_pkg.sv =====
// Shared types and constants for the signed integer to decimal text unit.
// No dependencies; every other file of the unit refers to this package.
package sitda_pkg;

   localparam int VALUE_W = 32;
   localparam int CHAR_W  = 8;
   localparam int COUNT_W = 4;
   localparam int DIGIT_W = 4;
   localparam int MAX_DIGITS = 10;

   // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit unsigned x.
   localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
   localparam int                 RECIP_SHIFT = 35;

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

   typedef logic [DIGIT_W-1:0] digit_type;
   typedef logic [COUNT_W-1:0] count_type;

endpackage

// ===== hw/rtl/sitda_req_if.sv =====
// Request channel interface: one signed integer per beat.
// Depends on sitda_pkg for the payload width.
interface sitda_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [sitda_pkg::VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

// ===== hw/rtl/sitda_rsp_if.sv =====
// Response channel interface: one ASCII character per beat with run marks.
// Depends on sitda_pkg for the payload widths.
interface sitda_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sitda_pkg::CHAR_W-1:0]  character;
   logic                          last;
   logic [sitda_pkg::COUNT_W-1:0] char_count;

   modport source (output valid, output character, output last, output char_count,
                   input ready);
   modport sink (input valid, input character, input last, input char_count,
                 output ready);
endinterface

// ===== hw/rtl/signed_int_to_decimal_ascii_unit.sv =====
// Top level of the signed integer to decimal ASCII text unit.
// Depends on sitda_pkg, sitda_req_if and sitda_rsp_if.
//
// Each request beat carries a signed 32-bit value; the unit answers with its
// decimal text, one character per response beat, most significant first, with
// a leading '-' for negative values. Every beat carries the total character
// count and a last mark on the final character. Zero gives a single '0'.
// Digits are produced by one shared reciprocal multiplier (divide by ten), one
// digit per cycle, after a setup state; the characters then leave from the
// output register at one per cycle while the response side is ready.
// The request side is ready only while the unit is idle; the last character
// of a value may still wait at the output when the next value is accepted.
module signed_int_to_decimal_ascii_unit (
   input  logic        clock,
   input  logic        reset,
   sitda_req_if.sink   req_chan,
   sitda_rsp_if.source rsp_chan
);

   typedef enum logic [1:0] {
      IDLE,
      SETUP,
      DIGIT,
      EMIT
   } state_type;

   localparam int PROD_W = 2 * sitda_pkg::VALUE_W;

   state_type                         state_ff, state_in;
   logic [sitda_pkg::VALUE_W-1:0]     src_ff, src_in;
   logic [sitda_pkg::VALUE_W-1:0]     quot_ff, quot_in;
   logic                              neg_ff, neg_in;
   logic                              sign_pend_ff, sign_pend_in;
   sitda_pkg::count_type              ndig_ff, ndig_in;
   sitda_pkg::count_type              pos_ff, pos_in;
   sitda_pkg::count_type              total_ff, total_in;
   sitda_pkg::digit_type              digits_ff [sitda_pkg::MAX_DIGITS];
   sitda_pkg::digit_type              digits_in [sitda_pkg::MAX_DIGITS];
   logic                              valid_ff, valid_in;
   logic [sitda_pkg::CHAR_W-1:0]      char_ff, char_in;
   logic                              last_ff, last_in;
   sitda_pkg::count_type              count_ff, count_in;

   logic [sitda_pkg::VALUE_W-1:0]     mul_op;
   logic [PROD_W-1:0]                 product;
   logic [sitda_pkg::VALUE_W-1:0]     quot_next;
   logic [sitda_pkg::VALUE_W-1:0]     remainder;
   logic [sitda_pkg::VALUE_W-1:0]     in_raw;

   assign req_chan.ready      = (state_ff == IDLE);
   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.character  = char_ff;
   assign rsp_chan.last       = last_ff;
   assign rsp_chan.char_count = count_ff;

   // The single multiplier divides either the fresh magnitude or the last quotient.
   assign mul_op    = (state_ff == SETUP) ? src_ff : quot_ff;
   assign product   = PROD_W'(mul_op) * PROD_W'(sitda_pkg::RECIP_10);
   assign quot_next = sitda_pkg::VALUE_W'(product >> sitda_pkg::RECIP_SHIFT);
   assign remainder = src_ff - ((quot_ff << 3) + (quot_ff << 1));
   assign in_raw    = req_chan.value;

   always_comb begin
      state_in     = state_ff;
      src_in       = src_ff;
      quot_in      = quot_ff;
      neg_in       = neg_ff;
      sign_pend_in = sign_pend_ff;
      ndig_in      = ndig_ff;
      pos_in       = pos_ff;
      total_in     = total_ff;
      digits_in    = digits_ff;
      valid_in     = valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      count_in     = count_ff;

      if (valid_ff && rsp_chan.ready) begin
         valid_in = 1'b0;
      end

      case (state_ff)
         IDLE: begin
            if (req_chan.valid) begin
               neg_in   = in_raw[sitda_pkg::VALUE_W-1];
               src_in   = in_raw[sitda_pkg::VALUE_W-1] ? (~in_raw + 1'b1) : in_raw;
               ndig_in  = '0;
               state_in = SETUP;
            end
         end
         SETUP: begin
            quot_in  = quot_next;
            state_in = DIGIT;
         end
         DIGIT: begin
            // Digits are collected least significant first.
            digits_in[ndig_ff[sitda_pkg::COUNT_W-1:0]] = remainder[sitda_pkg::DIGIT_W-1:0];
            ndig_in = ndig_ff + 1'b1;
            if (quot_ff == '0) begin
               pos_in       = ndig_ff;
               sign_pend_in = neg_ff;
               total_in     = ndig_ff + 1'b1 + sitda_pkg::count_type'(neg_ff);
               state_in     = EMIT;
            end else begin
               src_in  = quot_ff;
               quot_in = quot_next;
            end
         end
         EMIT: begin
            if (!valid_ff || rsp_chan.ready) begin
               valid_in = 1'b1;
               count_in = total_ff;
               if (sign_pend_ff) begin
                  char_in      = sitda_pkg::ASCII_MINUS;
                  last_in      = 1'b0;
                  sign_pend_in = 1'b0;
               end else begin
                  char_in = sitda_pkg::ASCII_ZERO
                          + sitda_pkg::CHAR_W'(digits_ff[pos_ff]);
                  last_in = (pos_ff == '0);
                  pos_in  = pos_ff - 1'b1;
                  if (pos_ff == '0) begin
                     state_in = IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      src_ff       <= src_in;
      quot_ff      <= quot_in;
      neg_ff       <= neg_in;
      sign_pend_ff <= sign_pend_in;
      ndig_ff      <= ndig_in;
      pos_ff       <= pos_in;
      total_ff     <= total_in;
      digits_ff    <= digits_in;
      char_ff      <= char_in;
      last_ff      <= last_in;
      count_ff     <= count_in;
   end

endmodule
